// ===== design/swfa_pkg.sv =====
`timescale 1ns / 1ps

package swfa_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int TAP_W     = 16;
  localparam int TAP_COUNT = 8;
  localparam int TAP_IDX_W = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 16;
  // unsigned 16-bit sample times signed Q1.15 tap fits in 32 bits
  localparam int PROD_W    = 32;
  localparam int AVG_W     = 16;
  localparam int FILT_W    = 35;

  typedef struct packed {
    logic shift;    // new sample beat enters the window
    logic capture;  // product register takes the current window
  } cell_ctl_t;

endpackage

// ===== design/swfa_if.sv =====
`timescale 1ns / 1ps

interface swfa_in_if;
  logic                           valid;
  logic                           ready;
  logic [swfa_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swfa_out_if;
  logic                              valid;
  logic                              ready;
  logic [swfa_pkg::AVG_W-1:0]        window_average;
  logic signed [swfa_pkg::FILT_W-1:0] filtered_value;

  modport source (output valid, output window_average, output filtered_value, input ready);
  modport sink   (input valid, input window_average, input filtered_value, output ready);
endinterface

// ===== design/sample_window_fir_and_average_unit.sv =====
`timescale 1ns / 1ps

// Sliding-window FIR and moving average over the last DEPTH 16-bit samples.
// Samples shift through a row of DEPTH cells (cleared to zero at reset);
// each cell multiplies its sample by its Q1.15 tap, tap_0 weighting the
// oldest sample, and a registered adder tree forms the exact Q.15 sum.
// The average is floor(window sum / DEPTH) from a running sum and a
// reciprocal multiply. One sample beat is taken every cycle while results
// are taken; the pipeline has $clog2(DEPTH)+2 stages and the input stalls
// only when every stage holds a beat and the result is not taken. The
// clock period is set by the per-cell multiplier and one adder per tree
// level. Taps are written through cfg_we_i/cfg_idx_i/cfg_data_i; indexes 8
// and above are ignored.
module sample_window_fir_and_average_unit #(
  parameter int DEPTH = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  swfa_in_if.sink                          sample_chan_i,
  swfa_out_if.source                       result_chan_o,
  input  logic                             cfg_we_i,
  input  logic [swfa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [swfa_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int    LVL   = $clog2(DEPTH);
  localparam int    NST   = LVL + 2;
  localparam int    SUM_W = swfa_pkg::SAMPLE_W + LVL;
  localparam int    SH    = SUM_W + LVL;
  localparam int    MUL_W = SUM_W + 1;
  localparam longint MUL  = ((longint'(1) << SH) + DEPTH - 1) / DEPTH;
  localparam int    NW    = swfa_pkg::PROD_W + LVL;

  logic signed [swfa_pkg::TAP_W-1:0]  tap_q [swfa_pkg::TAP_COUNT];
  logic [NST-1:0]                     v_q;
  logic [NST:0]                       load;
  logic                               accept;
  swfa_pkg::cell_ctl_t                cell_ctl;
  logic [swfa_pkg::SAMPLE_W-1:0]      chain [DEPTH+1];
  logic signed [swfa_pkg::PROD_W-1:0] prod [DEPTH];
  logic [SUM_W-1:0]                   sum_q;
  logic [SUM_W+MUL_W-1:0]             avg_prod;
  logic [swfa_pkg::AVG_W-1:0]         avg_q [1:NST-1];
  logic [LVL-1:0]                     tree_en;
  logic signed [NW-1:0]               fir_sum;

  // tap registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < swfa_pkg::TAP_COUNT; i++) begin
        tap_q[i] <= '0;
      end
    end else if (cfg_we_i &&
                 (cfg_idx_i < swfa_pkg::CFG_IDX_W'(swfa_pkg::TAP_COUNT))) begin
      tap_q[cfg_idx_i[swfa_pkg::TAP_IDX_W-1:0]] <=
        cfg_data_i[swfa_pkg::TAP_W-1:0];
    end
  end

  // a stage loads when empty or when its beat moves on
  always_comb begin
    load[NST] = result_chan_o.ready;
    for (int i = NST - 1; i >= 0; i--) begin
      load[i] = !v_q[i] || load[i+1];
    end
  end

  assign accept              = sample_chan_i.valid && load[0];
  assign sample_chan_i.ready = load[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (load[0]) begin
        v_q[0] <= sample_chan_i.valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (load[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // window: cell 0 holds the newest sample, cell DEPTH-1 the oldest
  assign cell_ctl.shift   = accept;
  assign cell_ctl.capture = load[1];
  assign chain[0]         = sample_chan_i.sample;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    swfa_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (cell_ctl),
      .sample_i (chain[j]),
      .tap_i    (tap_q[DEPTH-1-j]),
      .sample_o (chain[j+1]),
      .prod_o   (prod[j])
    );
  end

  // running window sum: add the new sample, drop the one shifted out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (accept) begin
      sum_q <= sum_q + SUM_W'(sample_chan_i.sample) - SUM_W'(chain[DEPTH]);
    end
  end

  // floor(sum / DEPTH) by reciprocal, exact over the whole sum range
  assign avg_prod = sum_q * MUL_W'(MUL);

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      avg_q[1] <= avg_prod[SH +: swfa_pkg::AVG_W];
    end
    for (int i = 2; i < NST; i++) begin
      if (load[i]) begin
        avg_q[i] <= avg_q[i-1];
      end
    end
  end

  // tree level d (root is 0) sits in pipeline stage LVL+1-d
  for (genvar d = 0; d < LVL; d++) begin : g_tree_en
    assign tree_en[d] = load[LVL+1-d];
  end

  swfa_add_tree #(
    .N (DEPTH)
  ) u_tree (
    .clk_i (clk_i),
    .leaf_i(prod),
    .en_i  (tree_en),
    .sum_o (fir_sum)
  );

  assign result_chan_o.valid          = v_q[NST-1];
  assign result_chan_o.window_average = avg_q[NST-1];
  assign result_chan_o.filtered_value = swfa_pkg::FILT_W'(fir_sum);

endmodule

// ===== design/swfa_cell.sv =====
`timescale 1ns / 1ps

module swfa_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  swfa_pkg::cell_ctl_t                 ctl_i,
  input  logic [swfa_pkg::SAMPLE_W-1:0]       sample_i,
  input  logic signed [swfa_pkg::TAP_W-1:0]   tap_i,
  output logic [swfa_pkg::SAMPLE_W-1:0]       sample_o,
  output logic signed [swfa_pkg::PROD_W-1:0]  prod_o
);

  localparam int FULL_W = swfa_pkg::SAMPLE_W + swfa_pkg::TAP_W + 1;

  logic [swfa_pkg::SAMPLE_W-1:0]      sample_q;
  logic signed [swfa_pkg::PROD_W-1:0] prod_q;
  logic signed [FULL_W-1:0]           full_prod;

  // sample is unsigned, so zero-extend before the signed multiply
  assign full_prod = $signed({1'b0, sample_q}) * tap_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (ctl_i.shift) begin
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      prod_q <= full_prod[swfa_pkg::PROD_W-1:0];
    end
  end

  assign sample_o = sample_q;
  assign prod_o   = prod_q;

endmodule

// ===== design/swfa_add_tree.sv =====
`timescale 1ns / 1ps

module swfa_add_tree #(
  parameter int N = 8,
  localparam int LVL = $clog2(N)
) (
  input  logic                                    clk_i,
  input  logic signed [swfa_pkg::PROD_W-1:0]      leaf_i [N],
  input  logic [LVL-1:0]                          en_i,
  output logic signed [swfa_pkg::PROD_W+LVL-1:0]  sum_o
);

  localparam int LEAVES = 2 ** LVL;
  localparam int NW     = swfa_pkg::PROD_W + LVL;

  logic signed [NW-1:0] leaf   [LEAVES];
  // heap order: node k sums nodes 2k and 2k+1, root at 1
  logic signed [NW-1:0] node_q [1:LEAVES-1];

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign leaf[i] = NW'(leaf_i[i]);
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  for (genvar d = 0; d < LVL; d++) begin : g_lvl
    for (genvar i = 0; i < 2 ** d; i++) begin : g_node
      localparam int K = 2 ** d + i;
      if (d == LVL - 1) begin : g_bottom
        always_ff @(posedge clk_i) begin
          if (en_i[d]) begin
            node_q[K] <= leaf[2*K-LEAVES] + leaf[2*K+1-LEAVES];
          end
        end
      end else begin : g_inner
        always_ff @(posedge clk_i) begin
          if (en_i[d]) begin
            node_q[K] <= node_q[2*K] + node_q[2*K+1];
          end
        end
      end
    end
  end

  assign sum_o = node_q[1];

endmodule

// ===== design/swfa_checker.sv =====
`timescale 1ns / 1ps

module swfa_checker #(
  parameter int DEPTH = 8
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic [swfa_pkg::AVG_W-1:0]          out_avg_i,
  input logic signed [swfa_pkg::FILT_W-1:0]  out_filt_i
);

  localparam int NST   = $clog2(DEPTH) + 2;
  localparam int CNT_W = $clog2(NST + 1) + 1;

  logic [CNT_W-1:0] cnt_q;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // beats taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_avg_i) && $stable(out_filt_i))
    else $error("result beat changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result beat without a pending sample");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NST))
    else $error("more samples in flight than pipeline stages");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output stage is empty");

endmodule

bind sample_window_fir_and_average_unit swfa_checker #(
  .DEPTH (DEPTH)
) u_swfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_chan_i.valid),
  .in_ready_i  (sample_chan_i.ready),
  .out_valid_i (result_chan_o.valid),
  .out_ready_i (result_chan_o.ready),
  .out_avg_i   (result_chan_o.window_average),
  .out_filt_i  (result_chan_o.filtered_value)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH        = 8;
  localparam int LATENCY      = $clog2(DEPTH) + 1;
  localparam int DRAIN_CYCLES = 4 * LATENCY + 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RAND_PHASES  = 7;
  localparam int PHASE_ITEMS  = 200;

  typedef struct packed {
    logic [swfa_pkg::AVG_W-1:0]         average;
    logic signed [swfa_pkg::FILT_W-1:0] fir;
  } result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [swfa_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [swfa_pkg::CFG_W-1:0]     cfg_data_i;

  swfa_in_if  sample_bus ();
  swfa_out_if result_bus ();

  sample_window_fir_and_average_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_chan_i(sample_bus),
    .result_chan_o(result_bus),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: sample ring and tap copy
  logic [swfa_pkg::SAMPLE_W-1:0]     window_samples [DEPTH] = '{default: '0};
  int unsigned                       newest_slot            = 0;
  logic signed [swfa_pkg::TAP_W-1:0] coef_regs [swfa_pkg::TAP_COUNT] = '{default: '0};

  logic [swfa_pkg::SAMPLE_W-1:0] pending_samples [$];
  result_t                       awaited_results [$];
  int unsigned                   samples_queued  = 0;
  int unsigned                   samples_taken   = 0;
  int unsigned                   results_checked = 0;
  int unsigned                   tap_settings    = 0;
  int unsigned                   fail_count      = 0;
  int unsigned                   cycle_count     = 0;
  logic                          sample_taken    = 1'b0;

  function automatic result_t slide_window(input logic [swfa_pkg::SAMPLE_W-1:0] s);
    longint unsigned total;
    longint          fir_sum;
    int unsigned     slot;
    result_t         r;
    newest_slot = (newest_slot + 1) % DEPTH;
    window_samples[newest_slot] = s;
    total   = 0;
    fir_sum = 0;
    for (int i = 0; i < DEPTH; i++) total += window_samples[i];
    for (int i = 0; i < DEPTH; i++) begin
      // walk from the oldest slot, which sits just past the newest
      slot = (newest_slot + 1 + i) % DEPTH;
      fir_sum += longint'(window_samples[slot]) * longint'(coef_regs[i]);
    end
    r.average = swfa_pkg::AVG_W'(total / DEPTH);
    r.fir     = swfa_pkg::FILT_W'(fir_sum);
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // sample beat monitor and result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      sample_taken <= sample_bus.valid && sample_bus.ready;
      if (sample_bus.valid && sample_bus.ready) begin
        awaited_results.push_back(slide_window(sample_bus.sample));
        samples_taken++;
      end
      if (result_bus.valid && result_bus.ready) begin
        if (awaited_results.size() == 0) begin
          note_failure($sformatf("result beat with none expected (avg %0d fir %0d)",
                                 result_bus.window_average, result_bus.filtered_value));
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (result_bus.window_average !== want.average)
            note_failure($sformatf("result %0d window_average: expected %0d got %0d",
                                   results_checked, want.average,
                                   result_bus.window_average));
          if (result_bus.filtered_value !== want.fir)
            note_failure($sformatf("result %0d filtered_value: expected %0d got %0d",
                                   results_checked, want.fir,
                                   result_bus.filtered_value));
        end
      end
    end
  end

  // sender: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!sample_bus.valid || sample_taken)) begin
      if (gap_left != 0) begin
        sample_bus.valid <= 1'b0;
        gap_left = gap_left - 1;
      end else if (pending_samples.size() != 0) begin
        sample_bus.valid  <= 1'b1;
        sample_bus.sample <= pending_samples.pop_front();
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        sample_bus.valid <= 1'b0;
      end
    end
  end

  // receiver: stalls follow a 32-bit pattern redrawn with a random density
  logic [31:0] stall_bits = '1;
  int          stall_pos  = 0;

  always @(negedge clk_i) begin
    if (stall_pos == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_bits = '1;
        1:       stall_bits = $urandom;
        2:       stall_bits = $urandom | $urandom;
        default: stall_bits = $urandom & $urandom;
      endcase
    end
    result_bus.ready <= stall_bits[stall_pos];
    stall_pos = (stall_pos + 1) % 32;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, awaited_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_tap(input int unsigned idx,
                           input logic [swfa_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= swfa_pkg::CFG_IDX_W'(idx);
    cfg_data_i <= val;
    if (idx < swfa_pkg::TAP_COUNT) coef_regs[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_sample(input logic [swfa_pkg::SAMPLE_W-1:0] s);
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  task automatic wait_idle();
    while (samples_taken != samples_queued || awaited_results.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int                            n;
    int                            run;
    logic [swfa_pkg::SAMPLE_W-1:0] s;
    logic [swfa_pkg::CFG_W-1:0]    tap_val;

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    sample_bus.valid  = 1'b0;
    sample_bus.sample = '0;
    result_bus.ready  = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // alternating-sign ramp; writes to unused indexes must not land anywhere
    for (int t = 0; t < swfa_pkg::TAP_COUNT; t++)
      write_tap(t, (t % 2) ? swfa_pkg::CFG_W'(-(t + 1) * 3001)
                           : swfa_pkg::CFG_W'((t + 1) * 3001));
    write_tap(9, 16'h7FFF);
    write_tap(15, 16'h8000);
    tap_settings++;
    // first samples mix with the zeroed ring, then fill it at full scale
    queue_sample(16'd1);
    queue_sample(16'd2);
    queue_sample(16'd3);
    queue_sample(16'hAAAA);
    queue_sample(16'h5555);
    repeat (DEPTH) queue_sample(16'hFFFF);
    wait_idle();

    // most negative and most positive filter sums
    for (int t = 0; t < swfa_pkg::TAP_COUNT; t++) write_tap(t, 16'h8000);
    tap_settings++;
    queue_sample(16'hFFFF);
    wait_idle();
    for (int t = 0; t < swfa_pkg::TAP_COUNT; t++) write_tap(t, 16'h7FFF);
    tap_settings++;
    queue_sample(16'hFFFF);
    wait_idle();

    // only oldest and newest weighted, to pin the tap order
    for (int t = 0; t < swfa_pkg::TAP_COUNT; t++) write_tap(t, 16'h0000);
    write_tap(0, 16'h0001);
    write_tap(swfa_pkg::TAP_COUNT - 1, 16'hFFFE);
    tap_settings++;
    queue_sample(16'h1234);
    queue_sample(16'h0000);
    queue_sample(16'h8000);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      for (int t = 0; t < swfa_pkg::TAP_COUNT; t++) begin
        case (ph % 3)
          0: tap_val = swfa_pkg::CFG_W'($urandom);
          1: begin
            case ($urandom_range(0, 4))
              0:       tap_val = 16'h8000;
              1:       tap_val = 16'h7FFF;
              2:       tap_val = 16'hFFFF;
              3:       tap_val = 16'h0001;
              default: tap_val = 16'h0000;
            endcase
          end
          default: tap_val = swfa_pkg::CFG_W'($urandom_range(0, 64)) - swfa_pkg::CFG_W'(32);
        endcase
        write_tap(t, tap_val);
      end
      if ($urandom_range(0, 1) == 0)
        write_tap($urandom_range(swfa_pkg::TAP_COUNT, 15), swfa_pkg::CFG_W'($urandom));
      tap_settings++;

      n = 0;
      while (n < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0:       s = '0;
          1:       s = '1;
          2:       s = swfa_pkg::SAMPLE_W'($urandom_range(0, 15));
          3:       s = 16'hFFFF - swfa_pkg::SAMPLE_W'($urandom_range(0, 15));
          default: s = swfa_pkg::SAMPLE_W'($urandom);
        endcase
        // constant runs settle the window onto one value
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(2, DEPTH + 2) : 1;
        repeat (run) queue_sample(s);
        n += run;
      end
      wait_idle();
    end

    $display("checked %0d results from %0d sample beats across %0d tap settings",
             results_checked, samples_taken, tap_settings);
    $display("%0d field mismatches seen", fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/swfa_pkg.sv
design/swfa_if.sv
design/swfa_cell.sv
design/swfa_add_tree.sv
design/sample_window_fir_and_average_unit.sv
design/swfa_checker.sv
dv/tb.sv
